@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the grain voice RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check on every rising edge of clk, hold off while rst_n is low.
`define ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Check on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_RST(label, prop)
`define ASSERT_ALWAYS(label, prop)

`endif

`endif

@@ rtl/ggv_pkg.sv @@
// ----------------------------------------------------------------------------
// ggv_pkg
// Types, codes and constants shared by the grain voice modules.
// ----------------------------------------------------------------------------
package ggv_pkg;

    // default store sizes and output saturation width
    localparam int SOURCE_DEPTH_DEF   = 65536;
    localparam int ENVELOPE_DEPTH_DEF = 8192;
    localparam int SAMPLE_BITS        = 16;

    // fixed field widths
    localparam int OUT_W   = 16;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 16;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 24;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_SRC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_ENV = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESTART  = 2'd3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_START    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_GRAIN    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SRC_LEN  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_RATE     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_VOLUME   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_PAN_LEFT = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_PAN_RGHT = 3'd6;

    // configuration reset values
    localparam logic [15:0] START_RST    = 16'd1;
    localparam logic [13:0] GRAIN_RST    = 14'd4410;
    localparam logic [16:0] SRC_LEN_RST  = 17'd65536;
    localparam logic [23:0] RATE_RST     = 24'd65536;
    localparam logic [15:0] VOLUME_RST   = 16'd16384;
    localparam logic [15:0] PAN_RST      = 16'd23170;

    // controller to datapath commands
    typedef struct packed {
        logic       src_load;
        logic       env_load;
        logic       restart;
        logic       mul;
        logic       point;
        logic       index;
        logic       read;
        logic [1:0] sel;
        logic       coef;
        logic       horner;
        logic       pan;
        logic       env_scale;
        logic       vol;
        logic       finish;
    } ggv_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic active;
        logic out_free;
    } ggv_status_t;

endpackage

@@ rtl/ggv_ram.sv @@
// ----------------------------------------------------------------------------
// ggv_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ggv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/ggv_ctrl.sv @@
// ----------------------------------------------------------------------------
// ggv_ctrl
// Sequencer for the grain voice: accepts items and steps the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ggv_ctrl
    import ggv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [KIND_W-1:0]    kind,
    input  ggv_status_t          status,
    output ggv_cmd_t             cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_POINT  = 4'd2;
    localparam logic [3:0] S_INDEX  = 4'd3;
    localparam logic [3:0] S_READ   = 4'd4;
    localparam logic [3:0] S_WAIT   = 4'd5;
    localparam logic [3:0] S_COEF   = 4'd6;
    localparam logic [3:0] S_HORNER = 4'd7;
    localparam logic [3:0] S_PAN    = 4'd8;
    localparam logic [3:0] S_ENV    = 4'd9;
    localparam logic [3:0] S_VOL    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [9:0] cmd_flags;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (kind)
                        KIND_LOAD_SRC: cmd.src_load = 1'b1;
                        KIND_LOAD_ENV: cmd.env_load = 1'b1;
                        KIND_RESTART:  cmd.restart  = 1'b1;
                        KIND_TICK:     state_next   = S_MUL;
                        default:       state_next   = S_IDLE;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = status.active ? S_POINT : S_DONE;
            end
            S_POINT:
            begin
                cmd.point  = 1'b1;
                state_next = S_INDEX;
            end
            S_INDEX:
            begin
                cmd.index  = 1'b1;
                cnt_next   = 2'd0;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read = 1'b1;
                cmd.sel  = cnt_reg;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_COEF;
            end
            S_COEF:
            begin
                cmd.coef   = 1'b1;
                cnt_next   = 2'd0;
                state_next = S_HORNER;
            end
            S_HORNER:
            begin
                cmd.horner = 1'b1;
                cmd.sel    = cnt_reg;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    state_next = S_PAN;
                end
            end
            S_PAN:
            begin
                cmd.pan    = 1'b1;
                state_next = S_ENV;
            end
            S_ENV:
            begin
                cmd.env_scale = 1'b1;
                state_next    = S_VOL;
            end
            S_VOL:
            begin
                cmd.vol    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign cmd_flags = {cmd.mul, cmd.point, cmd.index, cmd.read, cmd.coef,
                        cmd.horner, cmd.pan, cmd.env_scale, cmd.vol, cmd.finish};

    `ASSERT_ALWAYS(a_one_step_at_a_time, $onehot0(cmd_flags))
    `ASSERT_RST(a_finish_has_room, cmd.finish |-> status.out_free)
    `ASSERT_RST(a_tick_starts_work,
        (item_valid && !item_stall && kind == KIND_TICK) |=> (state_reg == S_MUL))

endmodule

@@ rtl/ggv_datapath.sv @@
// ----------------------------------------------------------------------------
// ggv_datapath
// Stores, configuration, read point, cubic Horner unit, gains and output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ggv_datapath
    import ggv_pkg::*;
#(
    parameter int SOURCE_DEPTH   = SOURCE_DEPTH_DEF,
    parameter int ENVELOPE_DEPTH = ENVELOPE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ggv_cmd_t                 cmd,
    output ggv_status_t              status,
    input  logic [ADDR_W-1:0]        address,
    input  logic signed [OUT_W-1:0]  sample_value,
    input  logic [15:0]              envelope_value,
    input  logic                     cfg_we,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CDATA_W-1:0]       cfg_data,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [OUT_W-1:0]  left_sample,
    output logic signed [OUT_W-1:0]  right_sample,
    output logic                     active,
    output logic                     last
);

    localparam int SRC_AW = $clog2(SOURCE_DEPTH);
    localparam int ENV_AW = $clog2(ENVELOPE_DEPTH);
    localparam int A_W    = 22;   // Horner accumulator
    localparam int X_W    = 17;   // signed fraction
    localparam int S_W    = 24;   // scaled channel value
    localparam int G_W    = 17;   // gain operand with sign bit
    localparam int PW     = 48;   // rounding width

    localparam logic signed [A_W-1:0] A_ONE  = 1;
    localparam logic signed [PW-1:0]  P_ONE  = 1;
    localparam logic signed [S_W-1:0] SAT_HI = S_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [S_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [PW-1:0] round_sh(input logic signed [PW-1:0] z,
                                                      input int n);
        return (z + (P_ONE <<< (n - 1))) >>> n;
    endfunction

    // configuration
    logic [15:0] start_reg;
    logic [13:0] grain_reg;
    logic [16:0] src_len_reg;
    logic [23:0] rate_reg;
    logic [15:0] vol_reg;
    logic [15:0] pan_l_reg;
    logic [15:0] pan_r_reg;

    // control state
    logic [13:0] pos_reg;
    logic        active_reg;
    logic        last_reg;
    logic        env_ok_reg;
    logic        inb_reg;
    logic        cap_valid_reg;
    logic [1:0]  cap_sel_reg;
    logic        result_valid_reg;

    // payload
    logic [37:0]                prod_reg;
    logic [38:0]                point_reg;
    logic [23:0]                idx_reg;
    logic signed [X_W-1:0]      x_reg;
    logic [15:0]                env_reg;
    logic signed [OUT_W-1:0]    y_reg [4];
    logic signed [A_W-1:0]      a_reg;
    logic signed [A_W-1:0]      c1_reg;
    logic signed [A_W-1:0]      c2_reg;
    logic signed [S_W-1:0]      sl_reg;
    logic signed [S_W-1:0]      sr_reg;
    logic signed [OUT_W-1:0]    left_reg;
    logic signed [OUT_W-1:0]    right_reg;
    logic                       act_out_reg;
    logic                       last_out_reg;

    // memory ports
    logic [31:0]          addr32;
    logic [31:0]          pos32;
    logic [31:0]          rd32;
    logic [23:0]          rd_idx;
    logic                 src_addr_ok;
    logic                 env_addr_ok;
    logic [SRC_AW-1:0]    src_addr;
    logic [ENV_AW-1:0]    env_addr;
    logic                 src_we;
    logic                 env_we;
    logic [OUT_W-1:0]     src_rdata;
    logic [15:0]          env_rdata;

    // arithmetic
    logic [38:0]               point_w;
    logic [15:0]               frac;
    logic [23:0]               idx_w;
    logic [31:0]               limit;
    logic                      inb_w;
    logic signed [A_W-1:0]     y0e, y1e, y2e, y3e;
    logic signed [A_W-1:0]     h_add;
    logic signed [A_W+X_W-1:0] h_prod;
    logic signed [A_W-1:0]     v_w;
    logic signed [S_W-1:0]     ml_a_l, ml_a_r;
    logic [15:0]               gain_l, gain_r;
    logic signed [S_W+G_W-1:0] prod_l, prod_r;
    logic signed [S_W-1:0]     sat_l, sat_r;
    logic                      out_take;

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    assign addr32      = 32'(address);
    assign pos32       = 32'(pos_reg);
    assign rd_idx      = idx_reg + 24'(cmd.sel);
    assign rd32        = 32'(rd_idx);
    assign src_addr_ok = (addr32 < 32'(SOURCE_DEPTH));
    assign env_addr_ok = (addr32 < 32'(ENVELOPE_DEPTH));
    assign src_we      = cmd.src_load && src_addr_ok;
    assign env_we      = cmd.env_load && env_addr_ok;
    assign src_addr    = cmd.src_load ? addr32[SRC_AW-1:0] : rd32[SRC_AW-1:0];
    assign env_addr    = cmd.env_load ? addr32[ENV_AW-1:0] : pos32[ENV_AW-1:0];

    ggv_ram #(
        .WIDTH (OUT_W),
        .DEPTH (SOURCE_DEPTH)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .addr  (src_addr),
        .wdata (sample_value),
        .rdata (src_rdata)
    );

    ggv_ram #(
        .WIDTH (16),
        .DEPTH (ENVELOPE_DEPTH)
    ) u_env_ram (
        .clk   (clk),
        .we    (env_we),
        .addr  (env_addr),
        .wdata (envelope_value),
        .rdata (env_rdata)
    );

    // ------------------------------------------------------------------
    // Read point, index and bounds
    // ------------------------------------------------------------------
    assign point_w = 39'({start_reg, 16'h0000}) + 39'(prod_reg);
    assign frac    = point_reg[15:0];
    assign idx_w   = 24'(point_reg[38:16]) + 24'(frac != 16'h0000);
    assign limit   = (32'(src_len_reg) < 32'(SOURCE_DEPTH)) ? 32'(src_len_reg)
                                                             : 32'(SOURCE_DEPTH);
    assign inb_w   = (idx_w != 24'd0) && ((32'(idx_w) + 32'd3) < limit);

    // ------------------------------------------------------------------
    // Cubic coefficients and Horner step
    // ------------------------------------------------------------------
    assign y0e = A_W'(y_reg[0]);
    assign y1e = A_W'(y_reg[1]);
    assign y2e = A_W'(y_reg[2]);
    assign y3e = A_W'(y_reg[3]);

    always_comb
    begin
        case (cmd.sel)
            2'd0:    h_add = c2_reg;
            2'd1:    h_add = c1_reg;
            default: h_add = y1e <<< 1;
        endcase
    end

    assign h_prod = a_reg * x_reg;
    assign v_w    = (a_reg + A_ONE) >>> 1;

    // ------------------------------------------------------------------
    // Gain chain: pan, envelope, volume through one multiplier per channel
    // ------------------------------------------------------------------
    always_comb
    begin
        if (cmd.pan)
        begin
            ml_a_l = S_W'(v_w);
            ml_a_r = S_W'(v_w);
            gain_l = pan_l_reg;
            gain_r = pan_r_reg;
        end
        else if (cmd.env_scale)
        begin
            ml_a_l = sl_reg;
            ml_a_r = sr_reg;
            gain_l = env_reg;
            gain_r = env_reg;
        end
        else
        begin
            ml_a_l = sl_reg;
            ml_a_r = sr_reg;
            gain_l = vol_reg;
            gain_r = vol_reg;
        end
    end

    assign prod_l = ml_a_l * $signed({1'b0, gain_l});
    assign prod_r = ml_a_r * $signed({1'b0, gain_r});

    assign sat_l = (sl_reg > SAT_HI) ? SAT_HI : ((sl_reg < SAT_LO) ? SAT_LO : sl_reg);
    assign sat_r = (sr_reg > SAT_HI) ? SAT_HI : ((sr_reg < SAT_LO) ? SAT_LO : sr_reg);

    // ------------------------------------------------------------------
    // Status and output
    // ------------------------------------------------------------------
    assign out_take        = result_valid_reg && !result_stall;
    assign status.active   = (pos_reg < grain_reg);
    assign status.out_free = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;
    assign active       = act_out_reg;
    assign last         = last_out_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg        <= START_RST;
            grain_reg        <= GRAIN_RST;
            src_len_reg      <= SRC_LEN_RST;
            rate_reg         <= RATE_RST;
            vol_reg          <= VOLUME_RST;
            pan_l_reg        <= PAN_RST;
            pan_r_reg        <= PAN_RST;
            pos_reg          <= 14'd0;
            active_reg       <= 1'b0;
            last_reg         <= 1'b0;
            env_ok_reg       <= 1'b0;
            inb_reg          <= 1'b0;
            cap_valid_reg    <= 1'b0;
            cap_sel_reg      <= 2'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START:    start_reg   <= cfg_data[15:0];
                    CFG_GRAIN:    grain_reg   <= cfg_data[13:0];
                    CFG_SRC_LEN:  src_len_reg <= cfg_data[16:0];
                    CFG_RATE:     rate_reg    <= cfg_data[23:0];
                    CFG_VOLUME:   vol_reg     <= cfg_data[15:0];
                    CFG_PAN_LEFT: pan_l_reg   <= cfg_data[15:0];
                    CFG_PAN_RGHT: pan_r_reg   <= cfg_data[15:0];
                    default:      ;
                endcase
            end

            if (cmd.restart)
            begin
                pos_reg <= 14'd0;
            end
            else if (cmd.finish && active_reg)
            begin
                pos_reg <= pos_reg + 14'd1;
            end

            if (cmd.mul)
            begin
                active_reg <= (pos_reg < grain_reg);
                last_reg   <= ((15'(pos_reg) + 15'd1) == 15'(grain_reg));
                env_ok_reg <= (pos32 < 32'(ENVELOPE_DEPTH));
            end

            if (cmd.index)
            begin
                inb_reg <= inb_w;
            end

            cap_valid_reg <= cmd.read;
            cap_sel_reg   <= cmd.sel;

            if (cmd.finish)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= 38'(pos_reg) * 38'(rate_reg);
        end

        if (cmd.point)
        begin
            point_reg <= point_w;
            env_reg   <= env_ok_reg ? env_rdata : 16'h0000;
        end

        if (cmd.index)
        begin
            idx_reg <= idx_w;
            x_reg   <= (frac == 16'h0000) ? '0 : $signed({1'b1, frac});
        end

        if (cap_valid_reg)
        begin
            y_reg[cap_sel_reg] <= src_rdata;
        end

        if (cmd.coef)
        begin
            c1_reg <= y2e - y0e;
            c2_reg <= (y0e <<< 1) - (y1e <<< 2) - y1e + (y2e <<< 2) - y3e;
            a_reg  <= (y3e - y0e) + (y1e - y2e) + ((y1e - y2e) <<< 1);
        end
        else if (cmd.horner)
        begin
            a_reg <= A_W'(round_sh(PW'(h_prod), 16)) + h_add;
        end

        if (cmd.pan || cmd.env_scale || cmd.vol)
        begin
            sl_reg <= S_W'(round_sh(PW'(prod_l), 15));
            sr_reg <= S_W'(round_sh(PW'(prod_r), 15));
        end

        if (cmd.finish)
        begin
            act_out_reg  <= active_reg;
            last_out_reg <= active_reg && last_reg;
            left_reg     <= (active_reg && inb_reg) ? sat_l[OUT_W-1:0] : '0;
            right_reg    <= (active_reg && inb_reg) ? sat_r[OUT_W-1:0] : '0;
        end
    end

    `ASSERT_RST(a_pos_advances,
        (cmd.finish && active_reg) |=> (pos_reg == $past(pos_reg) + 14'd1))
    `ASSERT_RST(a_idle_result_silent,
        (result_valid && !active) |-> (left_sample == '0 && right_sample == '0 && !last))

endmodule

@@ rtl/granular_grain_voice_top.sv @@
// ----------------------------------------------------------------------------
// granular_grain_voice_top
// One voice of a granular synthesizer with four-point cubic interpolation.
// ----------------------------------------------------------------------------
// The voice holds a mono source store and an envelope store, filled by load
// items, and a 14-bit play position that a restart item sets back to zero.
// Each tick item reads the source at start_position + position * rate (Q.16),
// interpolates four neighboring samples with the cubic, scales the value by
// pan, envelope and volume gains, saturates each channel and returns one
// result item; loads and restarts return nothing. A load or restart item is
// taken without leaving idle. A tick inside the grain passes through the four
// sequential reads of the single-port source RAM, the three Horner steps
// through one shared multiplier and the three gain steps before its result
// lands in the output register; a tick past the grain length skips them. A
// result lands only when the output register is empty or being read. Items
// stall until then, and the next one is accepted the cycle after, even while
// the last result still waits in the output register. Configuration writes
// are taken in every cycle (cfg_ready is tied high) and must only occur while
// the voice is idle. Both stores come up undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module granular_grain_voice_top
    import ggv_pkg::*;
#(
    parameter int SOURCE_DEPTH   = SOURCE_DEPTH_DEF,
    parameter int ENVELOPE_DEPTH = ENVELOPE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,

    // item channel
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic [ADDR_W-1:0]        address,
    input  logic signed [OUT_W-1:0]  sample_value,
    input  logic [15:0]              envelope_value,

    // result channel
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [OUT_W-1:0]  left_sample,
    output logic signed [OUT_W-1:0]  right_sample,
    output logic                     active,
    output logic                     last,

    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CDATA_W-1:0]       cfg_data
);

    ggv_cmd_t    cmd;
    ggv_status_t status;
    logic        cfg_we;

    // Registers sit in flops and take a write directly, so always ready.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Sequencer: accept items in idle, then step the datapath per tick.
    ggv_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .kind       (kind),
        .status     (status),
        .cmd        (cmd)
    );

    // Stores, arithmetic and the output register.
    ggv_datapath #(
        .SOURCE_DEPTH   (SOURCE_DEPTH),
        .ENVELOPE_DEPTH (ENVELOPE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .address        (address),
        .sample_value   (sample_value),
        .envelope_value (envelope_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .active         (active),
        .last           (last)
    );

endmodule

@@ tb/granular_grain_voice_top_tb.sv @@
// ----------------------------------------------------------------------------
// granular_grain_voice_top_tb
// Self-checking bench for one grain voice with cubic interpolation.
// ----------------------------------------------------------------------------
// A window at the bottom of the source store, its last four entries and the
// front of the envelope store are filled at the start. Every setting keeps its
// reads inside them: random runs use a source length no longer than the
// window and a grain no longer than the filled envelope, so no read ever hits
// an entry that was never written. A directed part covers the reset settings,
// address extremes, source bounds at both ends, the last tick and past-grain
// ticks, masked register data and the unmapped register index. A longer grain
// over full-scale samples drives the cubic into overshoot. Random phases with
// fresh settings run restart-and-tick sequences with loads mixed in, plus
// noise items. A scoreboard class predicts every tick and checks each result
// field by field, in order.
// ----------------------------------------------------------------------------
module granular_grain_voice_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ggv_pkg::*;

    // register index with no register behind it
    localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 3'd7;
    // extra wait after the last expected result before touching config
    localparam int DRAIN_CYCLES     = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PRINT_CAP        = 100;
    // filled store regions; every setting keeps its reads inside them
    localparam int SRC_FILL         = 256;
    localparam int ENV_FILL         = 64;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               active;
        logic               final_tick;
    } grain_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of registers, stores and play position,
    // predicts each tick on acceptance and checks results against the oldest.
    // ------------------------------------------------------------------------
    class grain_voice_scoreboard;
        logic [15:0]   start_pos;
        logic [13:0]   grain_len;
        logic [16:0]   src_len;
        logic [23:0]   rate;
        logic [15:0]   volume;
        logic [15:0]   pan_left;
        logic [15:0]   pan_right;
        logic [13:0]   play_pos;
        shortint       source_mem [SOURCE_DEPTH_DEF];
        bit [15:0]     envelope_mem [ENVELOPE_DEPTH_DEF];
        grain_result_t expected_samples [$];
        int            errors;
        int            results_seen;

        function new();
            start_pos    = START_RST;
            grain_len    = GRAIN_RST;
            src_len      = SRC_LEN_RST;
            rate         = RATE_RST;
            volume       = VOLUME_RST;
            pan_left     = PAN_RST;
            pan_right    = PAN_RST;
            play_pos     = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        static function longint round_q(longint z, int n);
            return (z + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function logic [15:0] scale_channel(longint v, longint pan, longint env);
            longint s;
            s = round_q(v * pan, 15);
            s = round_q(s * env, 15);
            s = round_q(s * longint'(volume), 15);
            if (s > 32767)
                s = 32767;
            else if (s < -32768)
                s = -32768;
            return s[15:0];
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
            case (idx)
                CFG_START:    start_pos = data[15:0];
                CFG_GRAIN:    grain_len = data[13:0];
                CFG_SRC_LEN:  src_len   = data[16:0];
                CFG_RATE:     rate      = data;
                CFG_VOLUME:   volume    = data[15:0];
                CFG_PAN_LEFT: pan_left  = data[15:0];
                CFG_PAN_RGHT: pan_right = data[15:0];
                default: ;
            endcase
        endfunction

        function grain_result_t predict_tick();
            grain_result_t res;
            longint point, frac, idx, x_q, limit, env;
            longint y0, y1, y2, y3, acc, v;
            res = '0;
            if (play_pos >= grain_len)
                return res;
            res.active     = 1'b1;
            res.final_tick = (longint'(play_pos) + 1 == longint'(grain_len));
            point = (longint'(start_pos) << 16) + longint'(play_pos) * longint'(rate);
            frac  = point & 64'hFFFF;
            idx   = (point >>> 16) + ((frac != 0) ? 1 : 0);
            x_q   = (frac != 0) ? frac - 65536 : 0;
            limit = (longint'(src_len) < SOURCE_DEPTH_DEF) ? longint'(src_len)
                                                          : SOURCE_DEPTH_DEF;
            env = 0;
            if (play_pos < ENVELOPE_DEPTH_DEF)
                env = envelope_mem[play_pos];
            if (idx >= 1 && idx + 3 < limit) begin
                y0  = source_mem[idx];
                y1  = source_mem[idx + 1];
                y2  = source_mem[idx + 2];
                y3  = source_mem[idx + 3];
                // Horner on doubled coefficients, halve at the end
                acc = (y3 - y0) + 3 * (y1 - y2);
                acc = round_q(acc * x_q, 16) + (2 * y0 - 5 * y1 + 4 * y2 - y3);
                acc = round_q(acc * x_q, 16) + (y2 - y0);
                acc = round_q(acc * x_q, 16) + 2 * y1;
                v   = round_q(acc, 1);
                res.left  = scale_channel(v, pan_left, env);
                res.right = scale_channel(v, pan_right, env);
            end
            play_pos = play_pos + 14'd1;
            return res;
        endfunction

        function void note_item(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a,
                                logic [15:0] s, logic [15:0] e);
            case (k)
                KIND_LOAD_SRC:
                    if (int'(a) < SOURCE_DEPTH_DEF)
                        source_mem[a] = shortint'(s);
                KIND_LOAD_ENV:
                    if (int'(a) < ENVELOPE_DEPTH_DEF)
                        envelope_mem[a] = e;
                KIND_RESTART:
                    play_pos = '0;
                default:
                    expected_samples.push_back(predict_tick());
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            // keep the log short when something breaks badly
            if (errors <= PRINT_CAP)
                $display("ERROR: result %0d: %s", results_seen, what);
        endtask

        task check_result(logic signed [15:0] l, logic signed [15:0] r,
                          logic act, logic fin);
            grain_result_t want;
            results_seen++;
            if (expected_samples.size() == 0) begin
                report_mismatch("result with nothing expected");
                return;
            end
            want = expected_samples.pop_front();
            if (l !== want.left)
                report_mismatch($sformatf("left_sample %0d, want %0d", l, want.left));
            if (r !== want.right)
                report_mismatch($sformatf("right_sample %0d, want %0d", r, want.right));
            if (act !== want.active)
                report_mismatch($sformatf("active %b, want %b", act, want.active));
            if (fin !== want.final_tick)
                report_mismatch($sformatf("last %b, want %b", fin, want.final_tick));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_stall;
    logic [KIND_W-1:0]       kind;
    logic [ADDR_W-1:0]       address;
    logic signed [OUT_W-1:0] sample_value;
    logic [15:0]             envelope_value;
    logic                    result_valid;
    logic                    result_stall;
    logic signed [OUT_W-1:0] left_sample;
    logic signed [OUT_W-1:0] right_sample;
    logic                    active;
    logic                    last;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CIDX_W-1:0]       cfg_index;
    logic [CDATA_W-1:0]      cfg_data;

    grain_voice_scoreboard voice_sb = new();

    // idle bursts on both sides while set; cleared for quiet stretches
    bit gaps_on       = 1'b1;
    // bumped by the stimulus to ask the result side for one long hold
    int hold_requests = 0;

    granular_grain_voice_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .kind           (kind),
        .address        (address),
        .sample_value   (sample_value),
        .envelope_value (envelope_value),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .active         (active),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Item side. Every task here is entered right after a rising edge and
    // returns right after the edge that accepted its item, valid still high.
    // ------------------------------------------------------------------------
    task automatic send_item(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a,
                             logic [15:0] s, logic [15:0] e);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid     <= 1'b1;
        kind           <= k;
        address        <= a;
        sample_value   <= s;
        envelope_value <= e;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        voice_sb.note_item(k, a, s, e);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Drop valid, wait out every expected result, then the tail of any load.
    task automatic settle_voice();
        item_valid <= 1'b0;
        while (voice_sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        voice_sb.write_reg(idx, data);
    endtask

    // Write the whole register map while the voice is idle. Data wider than a
    // register is passed through on purpose: the voice must mask it.
    task automatic apply_setting(logic [CDATA_W-1:0] start_v, logic [CDATA_W-1:0] grain_v,
                                 logic [CDATA_W-1:0] src_v, logic [CDATA_W-1:0] rate_v,
                                 logic [CDATA_W-1:0] vol_v, logic [CDATA_W-1:0] pan_l_v,
                                 logic [CDATA_W-1:0] pan_r_v);
        settle_voice();
        write_cfg(CFG_START, start_v);
        write_cfg(CFG_GRAIN, grain_v);
        write_cfg(CFG_SRC_LEN, src_v);
        write_cfg(CFG_RATE, rate_v);
        write_cfg(CFG_VOLUME, vol_v);
        write_cfg(CFG_PAN_LEFT, pan_l_v);
        write_cfg(CFG_PAN_RGHT, pan_r_v);
        // unmapped index: must leave every register alone
        write_cfg(CFG_UNMAPPED, CDATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CDATA_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 24'd32768;
            1:       return 24'd0;
            2:       return CDATA_W'($urandom);
            default: return CDATA_W'($urandom_range(0, 32768));
        endcase
    endfunction

    // Mostly short grains with slow reads near the front of the source, so
    // sequences reach the last tick and the past-grain state; now and then a
    // fully random start or rate to hit the bounds checks. The source length
    // never exceeds the filled window and the grain never exceeds the filled
    // envelope; random upper bits above a register's width get masked away.
    task automatic apply_random_setting();
        logic [CDATA_W-1:0] s, g, l, r;
        case ($urandom_range(0, 3))
            0:       s = CDATA_W'($urandom_range(1, 200));
            1:       s = CDATA_W'($urandom_range(65500, 65535));
            2:       s = CDATA_W'($urandom);
            default: s = CDATA_W'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 3) != 0)
            g = CDATA_W'($urandom_range(1, 40));
        else
            g = {10'($urandom), 14'($urandom_range(1, ENV_FILL))};
        case ($urandom_range(0, 2))
            0:       l = CDATA_W'(SRC_FILL);
            1:       l = CDATA_W'($urandom_range(4, SRC_FILL));
            default: l = {7'($urandom), 17'($urandom_range(4, SRC_FILL))};
        endcase
        case ($urandom_range(0, 4))
            0:       r = 24'd65536;
            1:       r = CDATA_W'($urandom);
            2:       r = 24'd0;
            default: r = CDATA_W'($urandom_range(0, 32'h30000));
        endcase
        apply_setting(s, g, l, r, pick_gain(), pick_gain(), pick_gain());
    endtask

    // Restart-and-tick runs with loads near the read point, plus raw noise.
    task automatic run_random_phase(int n_items);
        int          sent;
        int          run_len;
        int          g;
        logic [15:0] near;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                send_item(KIND_W'($urandom_range(0, 3)), 16'($urandom),
                          16'($urandom), 16'($urandom));
                sent++;
            end
            else
            begin
                send_item(KIND_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
                sent++;
                g       = int'(voice_sb.grain_len);
                run_len = $urandom_range(1, (g > 45) ? 48 : g + 3);
                repeat (run_len)
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            near = 16'(longint'(voice_sb.start_pos) +
                                       ((longint'(voice_sb.play_pos) *
                                         longint'(voice_sb.rate)) >>> 16) +
                                       $urandom_range(0, 4));
                            send_item(KIND_LOAD_SRC, near, 16'($urandom), 16'($urandom));
                        end
                        1:
                            send_item(KIND_LOAD_ENV, 16'($urandom_range(0, g + 2)),
                                      16'($urandom), 16'($urandom));
                        default:
                            send_tick();
                    endcase
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check every accepted result, stall in random bursts, and
    // serve a long hold when asked so that the voice backs up into its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                voice_sb.check_result(left_sample, right_sample, active, last);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                stall_left   = LONG_HOLD_CYCLES;
            end
            else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        item_valid     <= 1'b0;
        kind           <= KIND_TICK;
        address        <= '0;
        sample_value   <= '0;
        envelope_value <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_START;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the bottom source window, the last four source entries and the
        // front of the envelope store; every read later lands in these.
        for (int i = 0; i < SRC_FILL; i++)
            send_item(KIND_LOAD_SRC, 16'(i), 16'($urandom), 16'($urandom));
        for (int i = SOURCE_DEPTH_DEF - 4; i < SOURCE_DEPTH_DEF; i++)
            send_item(KIND_LOAD_SRC, 16'(i), 16'($urandom), 16'($urandom));
        for (int i = 0; i < ENV_FILL; i++)
            send_item(KIND_LOAD_ENV, 16'(i), 16'($urandom), 16'($urandom));

        // Reset register values, untouched so far: position 0 and 1.
        send_tick();
        send_tick();

        // Start at zero (index below one), half-step rate, hard-left pan.
        // Load addresses at both ends, plus an envelope load past its store.
        apply_setting(24'd0, 24'd3, 24'd65536, 24'h008000, 24'd32768, 24'd32768, 24'd0);
        send_item(KIND_LOAD_SRC, 16'd0, 16'sd32767, 16'd0);
        send_item(KIND_LOAD_SRC, 16'hFFFF, -16'sd32768, 16'hFFFF);
        send_item(KIND_LOAD_ENV, 16'd0, 16'd0, 16'hFFFF);
        send_item(KIND_LOAD_ENV, 16'd8191, 16'd0, 16'd32768);
        send_item(KIND_LOAD_ENV, 16'hFFFF, 16'd0, 16'h1234);
        send_item(KIND_RESTART, 16'd0, 16'd0, 16'd0);
        // below source start, mid-sample, last tick, then two past the grain
        repeat (5) send_tick();

        // Top of the source with a tiny source length: always out of bounds.
        // All-ones data checks register masking; one-tick grain.
        apply_setting(24'hFFFFFF, 24'd1, 24'd4, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd32768);
        send_item(KIND_RESTART, 16'd0, 16'd0, 16'd0);
        send_tick();
        send_tick();

        // Last window that still fits the store: reads 65532..65535.
        apply_setting(24'd65532, 24'd2, 24'h1FFFF, 24'd0, 24'd32768, 24'hFFFF, 24'd32768);
        send_item(KIND_RESTART, 16'd0, 16'd0, 16'd0);
        send_tick();
        send_tick();

        // Longer grain over full-scale alternating samples, driving the cubic
        // into overshoot and the gains into saturation.
        send_item(KIND_LOAD_SRC, 16'd200, 16'sd32767, 16'd0);
        send_item(KIND_LOAD_SRC, 16'd201, -16'sd32768, 16'd0);
        send_item(KIND_LOAD_SRC, 16'd202, 16'sd32767, 16'd0);
        send_item(KIND_LOAD_SRC, 16'd203, -16'sd32768, 16'd0);
        apply_setting(24'd200, 24'd8200, 24'd65536, 24'd3, 24'd32768, 24'hFFFF, 24'd32768);
        send_item(KIND_RESTART, 16'd0, 16'd0, 16'd0);
        repeat (40) send_tick();

        // Random phases. The second one asks for a long result hold while
        // items keep coming; the fourth and the last run without idling.
        for (int phase = 0; phase < 8; phase++)
        begin
            apply_random_setting();
            gaps_on = (phase != 3 && phase != 7);
            if (phase == 1)
                hold_requests++;
            run_random_phase(75);
        end

        settle_voice();
        if (voice_sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Generous ceiling: several times the slowest legal run.
    initial
    begin : watchdog
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ granular_grain_voice_top.f @@
+incdir+rtl
rtl/ggv_pkg.sv
rtl/ggv_ram.sv
rtl/ggv_ctrl.sv
rtl/ggv_datapath.sv
rtl/granular_grain_voice_top.sv
tb/granular_grain_voice_top_tb.sv
